// File: rtl/cddc_pkg.sv
// Shared types, constants and calendar lookup functions for the date counter.
`default_nettype none

package cddc_pkg;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int SERIAL_W = 22;

   // Year divided by 100 as (year * DIV100_MUL) >> DIV100_SHIFT, exact below 43699.
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int MUL_W        = 13;
   localparam int PROD_W       = YEAR_W + MUL_W;
   localparam int QUOT_W       = PROD_W - DIV100_SHIFT;
   localparam int Y365_W       = YEAR_W + 9;
   localparam int LEAPS_W      = YEAR_W - 2;
   localparam int REM100_W     = 7;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

   localparam logic [SERIAL_W-1:0] SERIAL_RESET = 22'd366;

   typedef struct packed {
      logic accept_set;
      logic accept_add;
      logic div;
      logic leap;
      logic sum;
      logic step;
      logic flag_ovf;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic at_last;
   } status_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd2:                   len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

   // Days before the first of the month in a common year.
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
      logic [8:0] ms;
      unique case (m)
         4'd2:    ms = 9'd31;
         4'd3:    ms = 9'd59;
         4'd4:    ms = 9'd90;
         4'd5:    ms = 9'd120;
         4'd6:    ms = 9'd151;
         4'd7:    ms = 9'd181;
         4'd8:    ms = 9'd212;
         4'd9:    ms = 9'd243;
         4'd10:   ms = 9'd273;
         4'd11:   ms = 9'd304;
         4'd12:   ms = 9'd334;
         default: ms = 9'd0;
      endcase
      return ms;
   endfunction

endpackage

`default_nettype wire

// File: rtl/cddc_ctrl.sv
// Controller state machine that sequences set and add requests.
`default_nettype none

module cddc_ctrl
   import cddc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       req_type,
   input  status_type      status,
   output cmd_type         cmd,
   output logic            busy,
   output logic            rsp_valid
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SET_DIV  = 7'b0000010,
      ST_SET_LEAP = 7'b0000100,
      ST_SET_SUM  = 7'b0001000,
      ST_ADD_STEP = 7'b0010000,
      ST_DONE     = 7'b0100000,
      ST_SPARE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type) begin
                  cmd.accept_add = 1'b1;
                  state_in       = ST_ADD_STEP;
               end else begin
                  cmd.accept_set = 1'b1;
                  state_in       = ST_SET_DIV;
               end
            end
         end
         ST_SET_DIV: begin
            cmd.div  = 1'b1;
            state_in = ST_SET_LEAP;
         end
         ST_SET_LEAP: begin
            cmd.leap = 1'b1;
            state_in = ST_SET_SUM;
         end
         ST_SET_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DONE;
         end
         ST_ADD_STEP: begin
            if (status.cnt_zero) begin
               state_in = ST_DONE;
            end else if (status.at_last) begin
               // stop on the last date and flag the overflow
               cmd.flag_ovf = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

`default_nettype wire

// File: rtl/cddc_datapath.sv
// Date registers, serial number arithmetic and the one-day stepper.
`default_nettype none

module cddc_datapath
   import cddc_pkg::*;
#(
   parameter int MAX_YEAR   = 9999,
   parameter int COUNT_BITS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  cmd_type                    cmd,
   input  wire logic [DAY_W-1:0]      req_new_day,
   input  wire logic [MONTH_W-1:0]    req_new_month,
   input  wire logic [YEAR_W-1:0]     req_new_year,
   input  wire logic [COUNT_BITS-1:0] req_add_count,
   output status_type                 status,
   output logic [DAY_W-1:0]           day,
   output logic [MONTH_W-1:0]         month,
   output logic [YEAR_W-1:0]          year,
   output logic [SERIAL_W-1:0]        serial,
   output logic                       overflow
);

   localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(MAX_YEAR);

   logic [DAY_W-1:0]      day_ff;
   logic [MONTH_W-1:0]    month_ff;
   logic [YEAR_W-1:0]     year_ff;
   logic [SERIAL_W-1:0]   serial_ff;
   logic                  ovf_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [REM100_W-1:0]   rem100_ff;
   logic [1:0]            cent4_ff;
   logic [QUOT_W-1:0]     qy_ff;
   logic [QUOT_W-1:0]     qly_ff;
   logic [Y365_W-1:0]     y365_ff;
   logic [LEAPS_W-1:0]    leaps_ff;

   logic [MONTH_W-1:0]    month_clamp;
   logic [YEAR_W-1:0]     year_clamp;
   logic [YEAR_W-1:0]     ly;
   logic [PROD_W-1:0]     prod_y;
   logic [PROD_W-1:0]     prod_ly;
   logic [YEAR_W-1:0]     hundreds;
   logic                  leap;
   logic [DAY_W-1:0]      len;
   logic [DAY_W-1:0]      day_clamp;
   logic [SERIAL_W+1:0]   serial_sum;

   always_comb begin
      if (req_new_month < MONTH_JAN) begin
         month_clamp = MONTH_JAN;
      end else if (req_new_month > MONTH_DEC) begin
         month_clamp = MONTH_DEC;
      end else begin
         month_clamp = req_new_month;
      end
      if (req_new_year == '0) begin
         year_clamp = YEAR_W'(1);
      end else if (req_new_year > YEAR_MAX) begin
         year_clamp = YEAR_MAX;
      end else begin
         year_clamp = req_new_year;
      end
   end

   // January and February count leaps against the year before
   assign ly       = (month_ff > MONTH_FEB) ? year_ff : year_ff - YEAR_W'(1);
   assign prod_y   = PROD_W'(year_ff) * PROD_W'(DIV100_MUL);
   assign prod_ly  = PROD_W'(ly) * PROD_W'(DIV100_MUL);
   assign hundreds = YEAR_W'(qy_ff) * YEAR_W'(100);

   assign leap = (year_ff[1:0] == 2'd0) && ((rem100_ff != '0) || (cent4_ff == 2'd0));
   assign len  = month_len(month_ff, leap);

   always_comb begin
      day_clamp = (day_ff == '0) ? DAY_W'(1) : day_ff;
      if (day_clamp > len) begin
         day_clamp = len;
      end
   end

   assign serial_sum = (SERIAL_W+2)'(y365_ff) + (SERIAL_W+2)'(leaps_ff)
                     + (SERIAL_W+2)'(month_start(month_ff)) + (SERIAL_W+2)'(day_clamp);

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff    <= DAY_W'(1);
         month_ff  <= MONTH_JAN;
         year_ff   <= YEAR_W'(1);
         serial_ff <= SERIAL_RESET;
         ovf_ff    <= 1'b0;
         cnt_ff    <= '0;
         rem100_ff <= REM100_W'(1);
         cent4_ff  <= 2'd0;
      end else begin
         if (cmd.accept_set) begin
            // hold the raw day until the month length is known
            day_ff   <= req_new_day;
            month_ff <= month_clamp;
            year_ff  <= year_clamp;
            ovf_ff   <= 1'b0;
         end
         if (cmd.accept_add) begin
            cnt_ff <= req_add_count;
            ovf_ff <= 1'b0;
         end
         if (cmd.leap) begin
            rem100_ff <= REM100_W'(year_ff - hundreds);
            cent4_ff  <= qy_ff[1:0];
         end
         if (cmd.sum) begin
            day_ff    <= day_clamp;
            serial_ff <= serial_sum[SERIAL_W-1:0];
         end
         if (cmd.flag_ovf) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.step) begin
            cnt_ff    <= cnt_ff - COUNT_BITS'(1);
            serial_ff <= serial_ff + SERIAL_W'(1);
            if ((month_ff == MONTH_DEC) && (day_ff == DAY_LAST)) begin
               year_ff  <= year_ff + YEAR_W'(1);
               month_ff <= MONTH_JAN;
               day_ff   <= DAY_W'(1);
               if (rem100_ff == REM100_W'(99)) begin
                  rem100_ff <= '0;
                  cent4_ff  <= cent4_ff + 2'd1;
               end else begin
                  rem100_ff <= rem100_ff + REM100_W'(1);
               end
            end else if (day_ff >= len) begin
               month_ff <= month_ff + MONTH_W'(1);
               day_ff   <= DAY_W'(1);
            end else begin
               day_ff <= day_ff + DAY_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div) begin
         qy_ff   <= prod_y[PROD_W-1:DIV100_SHIFT];
         qly_ff  <= prod_ly[PROD_W-1:DIV100_SHIFT];
         y365_ff <= Y365_W'(year_ff) * Y365_W'(365);
      end
      if (cmd.leap) begin
         leaps_ff <= LEAPS_W'(ly >> 2) - LEAPS_W'(qly_ff) + LEAPS_W'(qly_ff >> 2);
      end
   end

   assign status.cnt_zero = (cnt_ff == '0);
   assign status.at_last  = (month_ff == MONTH_DEC) && (day_ff == DAY_LAST)
                          && (year_ff >= YEAR_MAX);

   assign day      = day_ff;
   assign month    = month_ff;
   assign year     = year_ff;
   assign serial   = serial_ff;
   assign overflow = ovf_ff;

endmodule

`default_nettype wire

// File: rtl/calendar_date_day_counter.sv
// Top level of the Gregorian date and serial day counter.
`default_nettype none

// A set request (req_type low) loads a clamped date and recomputes its serial
// day number in the states SET_DIV, SET_LEAP and SET_SUM; its result strobes
// in DONE, and the next request is taken back in IDLE. An add request steps
// the date one day per cycle through the stepper in the datapath. Each result
// is on the rsp_ ports for exactly one cycle with rsp_valid high; the receiver
// must take it then. busy stays high from the request until the result cycle
// ends.
module calendar_date_day_counter
   import cddc_pkg::*;
#(
   parameter int MAX_YEAR   = 9999,
   parameter int COUNT_BITS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_type,
   input  wire logic [DAY_W-1:0]      req_new_day,
   input  wire logic [MONTH_W-1:0]    req_new_month,
   input  wire logic [YEAR_W-1:0]     req_new_year,
   input  wire logic [COUNT_BITS-1:0] req_add_count,
   output logic                       rsp_valid,
   output logic [DAY_W-1:0]           rsp_cur_day,
   output logic [MONTH_W-1:0]         rsp_cur_month,
   output logic [YEAR_W-1:0]          rsp_cur_year,
   output logic [SERIAL_W-1:0]        rsp_serial_day,
   output logic                       rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   cddc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   cddc_datapath #(
      .MAX_YEAR   (MAX_YEAR),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_new_day   (req_new_day),
      .req_new_month (req_new_month),
      .req_new_year  (req_new_year),
      .req_add_count (req_add_count),
      .status        (status),
      .day           (rsp_cur_day),
      .month         (rsp_cur_month),
      .year          (rsp_cur_year),
      .serial        (rsp_serial_day),
      .overflow      (rsp_overflow)
   );

endmodule

`default_nettype wire
